@@ design/velocity_motion_model_predict_defines.svh @@
// Assertion macros for the velocity motion model predictor.
// Included by the top-level RTL file, which carries the concurrent checks; no other dependencies.
`ifndef VELOCITY_MOTION_MODEL_PREDICT_DEFINES_SVH
`define VELOCITY_MOTION_MODEL_PREDICT_DEFINES_SVH

`ifndef SYNTHESIS
// Check a property on the rising clock edge, disabled while reset is asserted.
`define VMM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check a property on every rising clock edge, reset included.
`define VMM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define VMM_ASSERT(lbl, clk, rst_n, prop, msg)
`define VMM_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

@@ design/vmm_pkg.sv @@
// Shared types, fixed-point constants and the CORDIC angle table of the predictor.
// No dependencies; imported by every cell and by the top level.
`default_nettype none

package vmm_pkg;

    // CORDIC datapath widths (Q4.30 vectors, Q5.30 residual angle)
    localparam int XY_W = 34;
    localparam int Z_W  = 35;

    localparam logic signed [Z_W-1:0]  PI_Q30      = 35'sd3373259426;
    localparam logic signed [Z_W-1:0]  HALF_PI_Q30 = 35'sd1686629713;
    localparam logic signed [XY_W-1:0] GAIN_Q30    = 34'sd652032874;

    // Heading constants, Q4.28
    localparam logic signed [30:0] PI_Q28     = 31'sd843314857;
    localparam logic signed [31:0] TWO_PI_32  = 32'sd1686629714;

    // Heading range reduction: non-negative residue, one step of 2*pi*2^k per cell
    localparam int RED_CELLS = 18;
    localparam int RED_W     = 49;
    localparam logic [RED_W-1:0] TWO_PI_RED = 49'd1686629714;
    localparam logic [RED_W-1:0] PI_RED     = 49'd843314857;
    localparam logic signed [51:0] RED_OFFSET = 52'sd843314857 + (52'sd1686629714 <<< 16);

    // Radius divider: |v|*2^16 over |w|, one quotient bit per cell
    localparam int DIV_CELLS = 48;
    localparam int DIV_NUM_W = 48;
    localparam int DIV_DEN_W = 32;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic                   flip;
    } cord_t;

    typedef struct packed {
        logic [DIV_DEN_W-1:0] rem;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_NUM_W-1:0] quo;
        logic [DIV_DEN_W-1:0] den;
        logic                 neg;
    } div_t;

    // atan(2^-i) in Q2.30, truncated
    function automatic logic signed [Z_W-1:0] atan_entry(input int i);
        logic signed [Z_W-1:0] r;
        case (i)
            0:       r = 35'sd843314856;
            1:       r = 35'sd497837829;
            2:       r = 35'sd263043836;
            3:       r = 35'sd133525158;
            4:       r = 35'sd67021686;
            5:       r = 35'sd33543515;
            6:       r = 35'sd16775850;
            7:       r = 35'sd8388437;
            8:       r = 35'sd4194282;
            9:       r = 35'sd2097149;
            10:      r = 35'sd1048575;
            default: r = (i <= 30) ? Z_W'((64'sd1 <<< (30 - i)) - 64'sd1) : '0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

@@ design/velocity_motion_model_predict.sv @@
// Velocity motion model prediction (EKF), fixed point, fully pipelined: one pose request
// enters per clock and one result leaves per clock, in order, unless the pipe stalls or
// the receiver holds off. The pipe depth is set by the longer of two cell rows: heading
// reduction (18 cells) followed by the CORDIC (CORDIC_STAGES + 2), or the 48-cell radius
// divider for v/w. Positions, velocities and Jacobian terms are Q16.16, heading is Q4.28
// radians wrapped to [-pi, pi), the time step is unsigned Q0.16. A zero turn rate selects
// straight-line motion. A two-entry output buffer keeps the pipe moving while one result
// waits; the pipe stalls only when both entries are full.
// Depends on vmm_pkg, vmm_delay, vmm_wrap_cell, vmm_div_cell, vmm_cordic.
`default_nettype none
`include "velocity_motion_model_predict_defines.svh"

module velocity_motion_model_predict #(
    parameter int CORDIC_STAGES = 24
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // pose_x[31:0], pose_y[63:32], pose_heading[94:64], lin_velocity[126:95],
    // turn_rate[158:127], time_step[174:159], zero[175]
    input  logic [175:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // next_x[31:0], next_y[63:32], next_heading[94:64], jac_x_heading[126:95],
    // jac_y_heading[158:127], zero[159]
    output logic [159:0] m_tdata
);
    import vmm_pkg::*;

    localparam int RED_LAT  = RED_CELLS + 1;
    localparam int TRIG_LAT = RED_LAT + CORDIC_STAGES + 2;
    localparam int DIV_LAT  = DIV_CELLS + 1;
    localparam int MID_LAT  = (TRIG_LAT > DIV_LAT) ? TRIG_LAT : DIV_LAT;
    localparam int LAT      = MID_LAT + 8;
    localparam int SIDE_W   = 32 + 32 + 32 + 16 + 1;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [15:0]        dt;
        logic               wz;
        logic signed [30:0] nh;
    } tail_t;

    function automatic logic [31:0] sat32(input logic signed [38:0] v);
        if (v > 39'sd2147483647) begin
            return 32'h7fff_ffff;
        end else if (v < -39'sd2147483648) begin
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    // ---------------------------------------------------------------- flow control
    logic           en;
    logic           push;
    logic [LAT-1:0] vld_reg;
    logic           out_valid_reg;
    logic           skid_valid_reg;
    logic [159:0]   out_data_reg;
    logic [159:0]   skid_data_reg;
    logic [159:0]   push_data;

    // advance the whole pipe unless the skid entry is occupied
    assign en       = !skid_valid_reg;
    assign s_tready = en;
    assign push     = vld_reg[LAT-1] && en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
        end
    end

    // ---------------------------------------------------------------- stage 0
    // unpack, wrap the incoming heading once, form w*dt
    logic signed [30:0] in_hd;
    logic signed [31:0] in_w;
    logic [15:0]        in_dt;
    logic signed [31:0] hd_fix;
    logic signed [48:0] prod_next;

    assign in_hd = s_tdata[94:64];
    assign in_w  = s_tdata[158:127];
    assign in_dt = s_tdata[174:159];

    always_comb begin
        hd_fix = 32'(in_hd);
        if (in_hd >= PI_Q28) begin
            hd_fix = 32'(in_hd) - TWO_PI_32;
        end else if (in_hd < -PI_Q28) begin
            hd_fix = 32'(in_hd) + TWO_PI_32;
        end
        prod_next = 49'(in_w) * 49'($signed({1'b0, in_dt}));
    end

    logic signed [31:0] s0_x_reg, s0_y_reg, s0_v_reg, s0_w_reg;
    logic signed [30:0] s0_hd_reg;
    logic [15:0]        s0_dt_reg;
    logic signed [48:0] s0_prod_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            s0_x_reg    <= s_tdata[31:0];
            s0_y_reg    <= s_tdata[63:32];
            s0_hd_reg   <= hd_fix[30:0];
            s0_v_reg    <= s_tdata[126:95];
            s0_w_reg    <= in_w;
            s0_dt_reg   <= in_dt;
            s0_prod_reg <= prod_next;
        end
    end

    // ---------------------------------------------------------------- stage 1
    // round the heading step, offset to a non-negative residue, seed the divider
    logic signed [48:0] dtheta;
    logic signed [51:0] u_wide;
    logic [31:0]        abs_v;
    logic [31:0]        abs_w;
    div_t               div_seed;

    always_comb begin
        dtheta  = (s0_prod_reg + 49'sd8) >>> 4;
        u_wide  = 52'(s0_hd_reg) + 52'(dtheta) + RED_OFFSET;
        abs_v   = s0_v_reg[31] ? 32'(-s0_v_reg) : 32'(s0_v_reg);
        abs_w   = s0_w_reg[31] ? 32'(-s0_w_reg) : 32'(s0_w_reg);
        div_seed.rem = '0;
        div_seed.num = {abs_v, 16'd0};
        div_seed.quo = '0;
        div_seed.den = abs_w;
        div_seed.neg = s0_v_reg[31] ^ s0_w_reg[31];
    end

    logic [RED_W-1:0]   s1_u_reg;
    logic signed [30:0] s1_hd_reg;
    div_t               s1_div_reg;
    logic [SIDE_W-1:0]  s1_side_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_u_reg    <= u_wide[RED_W-1:0];
            s1_hd_reg   <= s0_hd_reg;
            s1_div_reg  <= div_seed;
            s1_side_reg <= {s0_x_reg, s0_y_reg, s0_v_reg, s0_dt_reg, (s0_w_reg == 32'sd0)};
        end
    end

    // ---------------------------------------------------------------- heading reduction
    logic [RED_W-1:0]   red_chain [RED_CELLS+1];
    logic [RED_W-1:0]   red_diff;
    logic signed [30:0] nh_reg;

    assign red_chain[0] = s1_u_reg;

    genvar g;
    generate
        for (g = 0; g < RED_CELLS; g++) begin : g_red
            vmm_wrap_cell #(.K(RED_CELLS - 1 - g)) u_cell (
                .aclk (aclk),
                .en   (en),
                .d    (red_chain[g]),
                .q    (red_chain[g+1])
            );
        end
    endgenerate

    assign red_diff = red_chain[RED_CELLS] - PI_RED;

    always_ff @(posedge aclk) begin
        if (en) begin
            nh_reg <= red_diff[30:0];
        end
    end

    // ---------------------------------------------------------------- sine and cosine
    logic signed [30:0] hd_aligned;
    logic signed [31:0] c0, s0, c1, s1;

    vmm_delay #(.WIDTH(31), .DEPTH(RED_LAT)) u_hd_dly (
        .aclk (aclk),
        .en   (en),
        .d    (s1_hd_reg),
        .q    (hd_aligned)
    );

    vmm_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_cur (
        .aclk    (aclk),
        .en      (en),
        .angle   (hd_aligned),
        .cos_q30 (c0),
        .sin_q30 (s0)
    );

    vmm_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_next (
        .aclk    (aclk),
        .en      (en),
        .angle   (nh_reg),
        .cos_q30 (c1),
        .sin_q30 (s1)
    );

    // ---------------------------------------------------------------- radius divider
    div_t               div_chain [DIV_CELLS+1];
    div_t               div_last;
    logic [31:0]        r_next;
    logic signed [31:0] r_reg;

    assign div_chain[0] = s1_div_reg;

    generate
        for (g = 0; g < DIV_CELLS; g++) begin : g_div
            vmm_div_cell u_cell (
                .aclk (aclk),
                .en   (en),
                .d    (div_chain[g]),
                .q    (div_chain[g+1])
            );
        end
    endgenerate

    assign div_last = div_chain[DIV_CELLS];

    // restore the sign and saturate to 32 bits
    always_comb begin
        if (!div_last.neg) begin
            r_next = (div_last.quo > 48'd2147483647) ? 32'h7fff_ffff : div_last.quo[31:0];
        end else begin
            r_next = (div_last.quo > 48'd2147483648) ? 32'h8000_0000
                                                     : (~div_last.quo[31:0] + 32'd1);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            r_reg <= r_next;
        end
    end

    // ---------------------------------------------------------------- alignment
    logic [127:0]       trig_mid;
    logic signed [31:0] mr;
    logic signed [30:0] mnh;
    logic [SIDE_W-1:0]  side_mid;

    vmm_delay #(.WIDTH(128), .DEPTH(MID_LAT - TRIG_LAT)) u_trig_dly (
        .aclk (aclk),
        .en   (en),
        .d    ({c0, s0, c1, s1}),
        .q    (trig_mid)
    );

    vmm_delay #(.WIDTH(32), .DEPTH(MID_LAT - DIV_LAT)) u_r_dly (
        .aclk (aclk),
        .en   (en),
        .d    (r_reg),
        .q    (mr)
    );

    vmm_delay #(.WIDTH(31), .DEPTH(MID_LAT - RED_LAT)) u_nh_dly (
        .aclk (aclk),
        .en   (en),
        .d    (nh_reg),
        .q    (mnh)
    );

    vmm_delay #(.WIDTH(SIDE_W), .DEPTH(MID_LAT)) u_side_dly (
        .aclk (aclk),
        .en   (en),
        .d    (s1_side_reg),
        .q    (side_mid)
    );

    logic signed [31:0] mc0, ms0, mc1, ms1, mx, my, mv;
    logic [15:0]        mdt;
    logic               mwz;
    tail_t              m0_tail;

    assign mc0 = trig_mid[127:96];
    assign ms0 = trig_mid[95:64];
    assign mc1 = trig_mid[63:32];
    assign ms1 = trig_mid[31:0];
    assign mx  = side_mid[112:81];
    assign my  = side_mid[80:49];
    assign mv  = side_mid[48:17];
    assign mdt = side_mid[16:1];
    assign mwz = side_mid[0];

    assign m0_tail.x  = mx;
    assign m0_tail.y  = my;
    assign m0_tail.dt = mdt;
    assign m0_tail.wz = mwz;
    assign m0_tail.nh = mnh;

    // ---------------------------------------------------------------- M1: operands
    // straight motion scales v by the current trig, arc motion scales r by differences
    logic signed [31:0] m1_a_reg;
    logic signed [32:0] m1_b1_reg, m1_b2_reg, m1_b3_reg;
    tail_t              m1_tail_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            m1_a_reg    <= mwz ? mv : mr;
            m1_b1_reg   <= mwz ? 33'(mc0) : 33'(ms1) - 33'(ms0);
            m1_b2_reg   <= mwz ? 33'(ms0) : 33'(mc0) - 33'(mc1);
            m1_b3_reg   <= 33'(mc1) - 33'(mc0);
            m1_tail_reg <= m0_tail;
        end
    end

    // ---------------------------------------------------------------- M2: products
    logic signed [64:0] m2_p1_reg, m2_p2_reg, m2_p3_reg;
    tail_t              m2_tail_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            m2_p1_reg   <= 65'(m1_a_reg) * 65'(m1_b1_reg);
            m2_p2_reg   <= 65'(m1_a_reg) * 65'(m1_b2_reg);
            m2_p3_reg   <= 65'(m1_a_reg) * 65'(m1_b3_reg);
            m2_tail_reg <= m1_tail_reg;
        end
    end

    // ---------------------------------------------------------------- M3: round to Q16.16
    logic signed [65:0] r1_sum, r2_sum, r3_sum;
    logic signed [35:0] m3_t1_reg, m3_t2_reg, m3_t3_reg;
    tail_t              m3_tail_reg;

    assign r1_sum = 66'(m2_p1_reg) + (66'sd1 <<< 29);
    assign r2_sum = 66'(m2_p2_reg) + (66'sd1 <<< 29);
    assign r3_sum = 66'(m2_p3_reg) + (66'sd1 <<< 29);

    always_ff @(posedge aclk) begin
        if (en) begin
            m3_t1_reg   <= r1_sum[65:30];
            m3_t2_reg   <= r2_sum[65:30];
            m3_t3_reg   <= r3_sum[65:30];
            m3_tail_reg <= m2_tail_reg;
        end
    end

    // ---------------------------------------------------------------- M4: scale by dt
    logic signed [52:0] m4_q1_reg, m4_q2_reg;
    logic signed [35:0] m4_t1_reg, m4_t2_reg, m4_t3_reg;
    tail_t              m4_tail_reg;
    logic signed [52:0] dt_ext;

    assign dt_ext = 53'($signed({1'b0, m3_tail_reg.dt}));

    always_ff @(posedge aclk) begin
        if (en) begin
            m4_q1_reg   <= 53'(m3_t1_reg) * dt_ext;
            m4_q2_reg   <= 53'(m3_t2_reg) * dt_ext;
            m4_t1_reg   <= m3_t1_reg;
            m4_t2_reg   <= m3_t2_reg;
            m4_t3_reg   <= m3_t3_reg;
            m4_tail_reg <= m3_tail_reg;
        end
    end

    // ---------------------------------------------------------------- M5: pick the case
    logic signed [53:0] q1_sum, q2_sum;
    logic signed [37:0] sdx, sdy;
    logic signed [37:0] m5_dx_reg, m5_dy_reg, m5_jx_reg;
    tail_t              m5_tail_reg;

    assign q1_sum = 54'(m4_q1_reg) + 54'sd32768;
    assign q2_sum = 54'(m4_q2_reg) + 54'sd32768;
    assign sdx    = q1_sum[53:16];
    assign sdy    = q2_sum[53:16];

    always_ff @(posedge aclk) begin
        if (en) begin
            if (m4_tail_reg.wz) begin
                m5_dx_reg <= sdx;
                m5_dy_reg <= sdy;
                m5_jx_reg <= -sdy;
            end else begin
                m5_dx_reg <= 38'(m4_t1_reg);
                m5_dy_reg <= 38'(m4_t2_reg);
                m5_jx_reg <= 38'(m4_t3_reg);
            end
            m5_tail_reg <= m4_tail_reg;
        end
    end

    // ---------------------------------------------------------------- M6: add and saturate
    logic [31:0]        m6_x_reg, m6_y_reg, m6_jx_reg, m6_jy_reg;
    logic signed [30:0] m6_nh_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            m6_x_reg  <= sat32(39'(m5_tail_reg.x) + 39'(m5_dx_reg));
            m6_y_reg  <= sat32(39'(m5_tail_reg.y) + 39'(m5_dy_reg));
            m6_jx_reg <= sat32(39'(m5_jx_reg));
            m6_jy_reg <= sat32(39'(m5_dx_reg));
            m6_nh_reg <= m5_tail_reg.nh;
        end
    end

    assign push_data = {1'b0, m6_jy_reg, m6_jx_reg, m6_nh_reg, m6_y_reg, m6_x_reg};

    // ---------------------------------------------------------------- output buffer
    // front entry drives the port; hold a second result in the skid entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (!out_valid_reg || m_tready) begin
                if (skid_valid_reg) begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end else begin
                    out_valid_reg <= push;
                end
            end else if (push) begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_tready) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : push_data;
        end else if (push) begin
            skid_data_reg <= push_data;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // ---------------------------------------------------------------- checks
    `VMM_ASSERT(a_skid_needs_front, aclk, aresetn, !skid_valid_reg || out_valid_reg, "skid entry full while front entry empty")
    `VMM_ASSERT(a_no_drop, aclk, aresetn, (out_valid_reg && !m_tready) |=> out_valid_reg, "pending result lost")
    `VMM_ASSERT(a_heading_range, aclk, aresetn, !m_tvalid || ($signed(m_tdata[94:64]) >= -PI_Q28 && $signed(m_tdata[94:64]) < PI_Q28), "heading out of range")
    `VMM_ASSERT_ALWAYS(a_reset_clears, aclk, !aresetn |=> (!out_valid_reg && !skid_valid_reg), "reset left results pending")

endmodule

`default_nettype wire

@@ design/vmm_delay.sv @@
// Enable-gated shift line that aligns side data with the longer datapaths.
// No dependencies.
`default_nettype none

module vmm_delay #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [WIDTH-1:0] d,
    output logic [WIDTH-1:0] q
);

    generate
        if (DEPTH == 0) begin : g_none
            assign q = d;
        end else begin : g_line
            logic [WIDTH-1:0] taps_reg [DEPTH];
            always_ff @(posedge aclk) begin
                if (en) begin
                    taps_reg[0] <= d;
                    for (int k = 1; k < DEPTH; k++) begin
                        taps_reg[k] <= taps_reg[k-1];
                    end
                end
            end
            assign q = taps_reg[DEPTH-1];
        end
    endgenerate

endmodule

`default_nettype wire

@@ design/vmm_wrap_cell.sv @@
// One step of the heading range reduction: drop 2*pi*2^K if it fits.
// Depends on vmm_pkg.
`default_nettype none

module vmm_wrap_cell #(
    parameter int K = 0
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic [vmm_pkg::RED_W-1:0] d,
    output logic [vmm_pkg::RED_W-1:0] q
);
    import vmm_pkg::*;

    localparam logic [RED_W-1:0] STEP = TWO_PI_RED << K;

    logic [RED_W-1:0] q_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            q_reg <= (d >= STEP) ? d - STEP : d;
        end
    end

    assign q = q_reg;

endmodule

`default_nettype wire

@@ design/vmm_div_cell.sv @@
// One restoring division step of the radius divider: one quotient bit per cell.
// Depends on vmm_pkg.
`default_nettype none

module vmm_div_cell (
    input  logic          aclk,
    input  logic          en,
    input  vmm_pkg::div_t d,
    output vmm_pkg::div_t q
);
    import vmm_pkg::*;

    div_t                 q_reg;
    div_t                 q_next;
    logic [DIV_DEN_W:0]   rem_sh;
    logic [DIV_DEN_W:0]   den_ext;
    logic                 fit;

    always_comb begin
        rem_sh  = {d.rem, d.num[DIV_NUM_W-1]};
        den_ext = {1'b0, d.den};
        fit     = (rem_sh >= den_ext);
        q_next      = d;
        q_next.num  = {d.num[DIV_NUM_W-2:0], 1'b0};
        q_next.quo  = {d.quo[DIV_NUM_W-2:0], fit};
        q_next.rem  = fit ? DIV_DEN_W'(rem_sh - den_ext) : rem_sh[DIV_DEN_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

`default_nettype wire

@@ design/vmm_cordic_cell.sv @@
// One rotation-mode CORDIC micro-rotation, fixed shift STAGE.
// Depends on vmm_pkg.
`default_nettype none

module vmm_cordic_cell #(
    parameter int STAGE = 0
) (
    input  logic           aclk,
    input  logic           en,
    input  vmm_pkg::cord_t d,
    output vmm_pkg::cord_t q
);
    import vmm_pkg::*;

    localparam logic signed [Z_W-1:0] ATAN = atan_entry(STAGE);

    cord_t                  q_reg;
    cord_t                  q_next;
    logic signed [XY_W-1:0] sx;
    logic signed [XY_W-1:0] sy;

    always_comb begin
        sx     = d.x >>> STAGE;
        sy     = d.y >>> STAGE;
        q_next = d;
        if (d.z >= 0) begin
            q_next.x = d.x - sy;
            q_next.y = d.y + sx;
            q_next.z = d.z - ATAN;
        end else begin
            q_next.x = d.x + sy;
            q_next.y = d.y - sx;
            q_next.z = d.z + ATAN;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

`default_nettype wire

@@ design/vmm_cordic.sv @@
// Sine/cosine unit: quadrant fold, a row of CORDIC cells, sign restore.
// Depends on vmm_pkg and vmm_cordic_cell. The fold, every cell and the sign restore are registered.
`default_nettype none

module vmm_cordic #(
    parameter int STAGES = 24
) (
    input  logic               aclk,
    input  logic               en,
    input  logic signed [30:0] angle,
    output logic signed [31:0] cos_q30,
    output logic signed [31:0] sin_q30
);
    import vmm_pkg::*;

    cord_t                 chain [STAGES+1];
    cord_t                 pre_next;
    logic signed [Z_W-1:0] z4;
    logic signed [31:0]    cos_reg;
    logic signed [31:0]    sin_reg;
    cord_t                 last;

    // fold into [-pi/2, pi/2], remember the half turn
    always_comb begin
        z4            = Z_W'(angle) <<< 2;
        pre_next.x    = GAIN_Q30;
        pre_next.y    = '0;
        pre_next.z    = z4;
        pre_next.flip = 1'b0;
        if (z4 > HALF_PI_Q30) begin
            pre_next.z    = z4 - PI_Q30;
            pre_next.flip = 1'b1;
        end else if (z4 < -HALF_PI_Q30) begin
            pre_next.z    = z4 + PI_Q30;
            pre_next.flip = 1'b1;
        end
    end

    cord_t pre_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            pre_reg <= pre_next;
        end
    end
    assign chain[0] = pre_reg;

    genvar g;
    generate
        for (g = 0; g < STAGES; g++) begin : g_cell
            vmm_cordic_cell #(.STAGE(g)) u_cell (
                .aclk (aclk),
                .en   (en),
                .d    (chain[g]),
                .q    (chain[g+1])
            );
        end
    endgenerate

    assign last = chain[STAGES];

    always_ff @(posedge aclk) begin
        if (en) begin
            cos_reg <= 32'(last.flip ? -last.x : last.x);
            sin_reg <= 32'(last.flip ? -last.y : last.y);
        end
    end

    assign cos_q30 = cos_reg;
    assign sin_q30 = sin_reg;

endmodule

`default_nettype wire

@@ sim/velocity_motion_model_predict_test.sv @@
// Testbench for velocity_motion_model_predict: drives pose requests through the stream
// input with bursts and gaps, stalls the result stream, and checks every result field
// against a behavioral predictor. Depends on the RTL (vmm_pkg and the top level).
`timescale 1ns / 1ps

module velocity_motion_model_predict_test;

    localparam int  NUM_RANDOM  = 1530;
    localparam int  TRIG_STAGES = 24;
    localparam int  DRAIN_WAIT  = 120;  // well past the pipe latency

    // Fixed-point constants of the motion model
    localparam longint PI_H      = 64'sd843314857;
    localparam longint TWO_PI_H  = 64'sd1686629714;
    localparam longint PI_T      = 64'sd3373259426;
    localparam longint HALF_PI_T = 64'sd1686629713;
    localparam longint TRIG_GAIN = 64'sd652032874;
    localparam longint S32_MAX   = 64'sd2147483647;
    localparam longint S32_MIN   = -64'sd2147483648;

    // first member sits in the highest bits, so list the fields from the top down
    typedef struct packed {
        logic [15:0]        time_step;
        logic signed [31:0] turn_rate;
        logic signed [31:0] lin_velocity;
        logic signed [30:0] pose_heading;
        logic signed [31:0] pose_y;
        logic signed [31:0] pose_x;
    } pose_req_t;

    typedef struct packed {
        logic signed [31:0] jac_y_heading;
        logic signed [31:0] jac_x_heading;
        logic signed [30:0] next_heading;
        logic signed [31:0] next_y;
        logic signed [31:0] next_x;
    } pose_res_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [175:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [159:0] m_tdata;

    pose_req_t    pending_reqs[$];
    pose_res_t    predicted_poses[$];
    pose_req_t    held_req;
    int           error_count;
    int           accepted_reqs;
    int           checked_results;
    int           straight_reqs;
    int           arc_reqs;

    velocity_motion_model_predict #(
        .CORDIC_STAGES(TRIG_STAGES)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // ---------------------------------------------------------------- predictor

    function automatic longint round_shift(input longint v, input int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clamp32(input longint v);
        if (v > S32_MAX) begin
            return S32_MAX;
        end
        if (v < S32_MIN) begin
            return S32_MIN;
        end
        return v;
    endfunction

    // Wrap a Q4.28 angle into [-pi, pi)
    function automatic longint wrap_angle(input longint a);
        longint m;
        m = (a + PI_H) % TWO_PI_H;
        if (m < 0) begin
            m += TWO_PI_H;
        end
        return m - PI_H;
    endfunction

    function automatic longint arctan_step(input int i);
        case (i)
            0:       return 64'sd843314856;
            1:       return 64'sd497837829;
            2:       return 64'sd263043836;
            3:       return 64'sd133525158;
            4:       return 64'sd67021686;
            5:       return 64'sd33543515;
            6:       return 64'sd16775850;
            7:       return 64'sd8388437;
            8:       return 64'sd4194282;
            9:       return 64'sd2097149;
            10:      return 64'sd1048575;
            default: return (i <= 30) ? ((64'sd1 <<< (30 - i)) - 1) : 64'sd0;
        endcase
    endfunction

    // Rotation-mode CORDIC: Q4.28 angle in, Q2.30 cosine and sine out
    function automatic void sin_cos(input longint ang, output longint c, output longint s);
        longint z;
        longint x;
        longint y;
        longint nx;
        bit     flip;
        z = ang * 4;
        x = TRIG_GAIN;
        y = 0;
        flip = 1'b0;
        if (z > HALF_PI_T) begin
            z -= PI_T;
            flip = 1'b1;
        end else if (z < -HALF_PI_T) begin
            z += PI_T;
            flip = 1'b1;
        end
        for (int i = 0; i < TRIG_STAGES; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z -= arctan_step(i);
            end else begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z += arctan_step(i);
            end
            x = nx;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic pose_res_t predict_pose(input pose_req_t rq);
        pose_res_t r;
        longint px, py, hd, v, w, dt, nh;
        longint c0, s0, c1, s1, dx, dy, jx, jy, vc, vs, rad;
        px = rq.pose_x;
        py = rq.pose_y;
        hd = wrap_angle(longint'(rq.pose_heading));
        v  = rq.lin_velocity;
        w  = rq.turn_rate;
        dt = longint'({48'd0, rq.time_step});
        nh = wrap_angle(hd + round_shift(w * dt, 4));
        sin_cos(hd, c0, s0);
        if (w == 0) begin
            vc = round_shift(v * c0, 30);
            vs = round_shift(v * s0, 30);
            dx = round_shift(vc * dt, 16);
            dy = round_shift(vs * dt, 16);
            jx = -dy;
            jy = dx;
        end else begin
            rad = clamp32((v * 65536) / w);
            sin_cos(nh, c1, s1);
            dx = round_shift(rad * (s1 - s0), 30);
            dy = round_shift(rad * (c0 - c1), 30);
            jx = round_shift(rad * (c1 - c0), 30);
            jy = dx;
        end
        r.next_x        = 32'(clamp32(px + dx));
        r.next_y        = 32'(clamp32(py + dy));
        r.next_heading  = 31'(nh);
        r.jac_x_heading = 32'(clamp32(jx));
        r.jac_y_heading = 32'(clamp32(jy));
        return r;
    endfunction

    // ---------------------------------------------------------------- stimulus

    function automatic pose_req_t make_req(input longint px, input longint py,
                                           input longint hd, input longint v,
                                           input longint w, input longint dt);
        pose_req_t rq;
        rq.pose_x       = 32'(px);
        rq.pose_y       = 32'(py);
        rq.pose_heading = 31'(hd);
        rq.lin_velocity = 32'(v);
        rq.turn_rate    = 32'(w);
        rq.time_step    = 16'(dt);
        return rq;
    endfunction

    function automatic longint rand_signed(input int bound);
        return longint'($urandom_range(2 * bound)) - bound;
    endfunction

    function automatic pose_req_t random_req();
        pose_req_t rq;
        int        pick;
        pick = $urandom_range(99);
        if (pick < 60) begin
            // plausible vehicle motion: meters, a few m/s and rad/s, short steps
            rq = make_req(rand_signed(1 << 26), rand_signed(1 << 26),
                          rand_signed(843314856), rand_signed(30 << 16),
                          ($urandom_range(4) == 0) ? 0 : rand_signed(5 << 16),
                          $urandom_range(13107));
        end else if (pick < 85) begin
            // raw bits everywhere, including headings outside the range
            rq = make_req($urandom, $urandom, $urandom, $urandom,
                          ($urandom_range(5) == 0) ? 0 : $urandom, $urandom);
        end else begin
            // tiny turn rates push the radius into saturation, large positions
            // push the sums into saturation
            rq = make_req(($urandom_range(1) ? S32_MAX : S32_MIN) - rand_signed(1 << 20),
                          $urandom, rand_signed(843314857), $urandom,
                          rand_signed(3), $urandom_range(65535));
        end
        return rq;
    endfunction

    task automatic add_directed();
        // all zero, then the extremes of every field
        pending_reqs.push_back(make_req(0, 0, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(S32_MAX, S32_MAX, PI_H - 1, S32_MAX, 0, 65535));
        pending_reqs.push_back(make_req(S32_MIN, S32_MIN, -PI_H, S32_MIN, 0, 65535));
        pending_reqs.push_back(make_req(0, 0, PI_H - 1, S32_MAX, S32_MAX, 65535));
        pending_reqs.push_back(make_req(0, 0, -PI_H, S32_MIN, S32_MIN, 65535));
        // heading outside [-pi, pi): raw 31-bit extremes and exactly pi
        pending_reqs.push_back(make_req(0, 0, 64'sd1073741823, 1 << 16, 0, 1000));
        pending_reqs.push_back(make_req(0, 0, -64'sd1073741824, 1 << 16, 1 << 16, 1000));
        pending_reqs.push_back(make_req(0, 0, PI_H, 1 << 16, -(1 << 16), 1000));
        // straight motion at two headings
        pending_reqs.push_back(make_req(100 << 16, -50 << 16, PI_H / 2, 5 << 16, 0, 6554));
        pending_reqs.push_back(make_req(0, 0, -PI_H / 2, -3 << 16, 0, 32768));
        // zero time step, both cases
        pending_reqs.push_back(make_req(1 << 16, 2 << 16, PI_H / 3, 5 << 16, 0, 0));
        pending_reqs.push_back(make_req(1 << 16, 2 << 16, PI_H / 3, 5 << 16, 1 << 16, 0));
        // radius overflow
        pending_reqs.push_back(make_req(0, 0, PI_H / 4, S32_MAX, 1, 65535));
        pending_reqs.push_back(make_req(0, 0, PI_H / 4, S32_MIN, 1, 65535));
        pending_reqs.push_back(make_req(0, 0, -PI_H / 4, S32_MIN, -1, 65535));
        // sum overflow in both directions
        pending_reqs.push_back(make_req(S32_MAX, S32_MAX, 0, S32_MAX, 0, 65535));
        pending_reqs.push_back(make_req(S32_MIN, S32_MIN, -PI_H + 10, S32_MAX, 0, 65535));
        pending_reqs.push_back(make_req(S32_MAX, S32_MIN, PI_H / 2, S32_MAX, 7, 65535));
        // ordinary arcs, heading wraps across pi
        pending_reqs.push_back(make_req(10 << 16, 10 << 16, PI_H - 1000, 2 << 16, 3 << 16,
                                        20000));
        pending_reqs.push_back(make_req(-10 << 16, 3 << 16, -PI_H + 1000, 2 << 16,
                                        -(3 << 16), 20000));
    endtask

    // ---------------------------------------------------------------- request driver

    int burst_left;
    int gap_left;

    always @(posedge aclk) begin
        pose_req_t nxt;
        if (!aresetn) begin
            s_tvalid   <= 1'b0;
            s_tdata    <= '0;
            burst_left <= 0;
            gap_left   <= 0;
        end else begin
            // record the request the block takes at this edge
            if (s_tvalid && s_tready) begin
                predicted_poses.push_back(predict_pose(held_req));
                accepted_reqs++;
                if (held_req.turn_rate == 0) begin
                    straight_reqs++;
                end else begin
                    arc_reqs++;
                end
            end
            if (s_tvalid && !s_tready) begin
                // hold the request until it is taken
            end else if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                nxt = pending_reqs.pop_front();
                held_req <= nxt;
                s_tdata  <= {1'b0, nxt};
                s_tvalid <= 1'b1;
                if (burst_left > 1) begin
                    burst_left <= burst_left - 1;
                end else begin
                    // end the burst; often back to back with no gap at all
                    burst_left <= $urandom_range(1, 40);
                    gap_left   <= ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 9);
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- result monitor

    int stall_cycle;

    always @(posedge aclk) begin
        pose_res_t got;
        pose_res_t want;
        int        mode;
        if (!aresetn) begin
            m_tready    <= 1'b0;
            stall_cycle <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = pose_res_t'(m_tdata[158:0]);
                if (predicted_poses.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, m_tdata);
                    error_count++;
                end else begin
                    want = predicted_poses.pop_front();
                    checked_results++;
                    if (got.next_x !== want.next_x) begin
                        $display("%0t: next_x expected %0d actual %0d",
                                 $time, want.next_x, got.next_x);
                        error_count++;
                    end
                    if (got.next_y !== want.next_y) begin
                        $display("%0t: next_y expected %0d actual %0d",
                                 $time, want.next_y, got.next_y);
                        error_count++;
                    end
                    if (got.next_heading !== want.next_heading) begin
                        $display("%0t: next_heading expected %0d actual %0d",
                                 $time, want.next_heading, got.next_heading);
                        error_count++;
                    end
                    if (got.jac_x_heading !== want.jac_x_heading) begin
                        $display("%0t: jac_x_heading expected %0d actual %0d",
                                 $time, want.jac_x_heading, got.jac_x_heading);
                        error_count++;
                    end
                    if (got.jac_y_heading !== want.jac_y_heading) begin
                        $display("%0t: jac_y_heading expected %0d actual %0d",
                                 $time, want.jac_y_heading, got.jac_y_heading);
                        error_count++;
                    end
                    if (m_tdata[159] !== 1'b0) begin
                        $display("%0t: pad bit expected 0 actual %b", $time, m_tdata[159]);
                        error_count++;
                    end
                end
            end
            // rotate through always ready, light stalls, heavy back-pressure and a periodic pattern
            stall_cycle <= stall_cycle + 1;
            mode = (stall_cycle / 300) % 4;
            case (mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= ($urandom_range(3) != 0);
                2:       m_tready <= ($urandom_range(3) == 0);
                default: m_tready <= ((stall_cycle % 7) < 4);
            endcase
        end
    end

    // ---------------------------------------------------------------- sequence

    initial begin
        error_count     = 0;
        accepted_reqs   = 0;
        checked_results = 0;
        straight_reqs   = 0;
        arc_reqs        = 0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        m_tready        = 1'b0;
        aresetn         = 1'b0;
        add_directed();
        for (int i = 0; i < NUM_RANDOM; i++) begin
            pending_reqs.push_back(random_req());
        end
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        // advance until every request is taken and every result is back
        while (pending_reqs.size() > 0 || s_tvalid || predicted_poses.size() > 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (predicted_poses.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time,
                     predicted_poses.size());
            error_count++;
        end
        $display("Covered %0d pose requests (%0d straight, %0d arc), %0d results checked.",
                 accepted_reqs, straight_reqs, arc_reqs, checked_results);
        if (error_count == 0) begin
            $display("** velocity_motion_model_predict: PASSED **");
        end else begin
            $display("** velocity_motion_model_predict: FAILED **");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("Timeout with %0d results still outstanding.", predicted_poses.size());
        $display("** velocity_motion_model_predict: FAILED **");
        $finish;
    end

endmodule
